// File: rtl/core/dphpd_pkg.sv
// Shared types and constants of the DP hot-plug port arbiter.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package dphpd_pkg;

	localparam int MAX_PORTS_DEF  = 4;
	localparam int TIMER_BITS_DEF = 16;

	localparam int CFG_TICK_W  = 16;
	localparam int CFG_PORTS_W = 3;

	localparam logic [CFG_TICK_W-1:0]  SPACING_RST = 16'd2000;
	localparam logic [CFG_TICK_W-1:0]  PULSE_RST   = 16'd500;
	localparam logic [CFG_PORTS_W-1:0] PORTS_RST   = 3'd2;

	localparam logic [1:0] CFG_SPACING = 2'd0;
	localparam logic [1:0] CFG_PULSE   = 2'd1;
	localparam logic [1:0] CFG_PORTS   = 2'd2;

	localparam logic [1:0] ACT_ATTENTION = 2'd0;
	localparam logic [1:0] ACT_UNATTACH  = 2'd1;
	localparam logic [1:0] ACT_TICK      = 2'd2;

	typedef enum logic [2:0] {
		ST_APPLIED      = 3'd0,
		ST_OTHER_OWNS   = 3'd1,
		ST_IRQ_NO_LEVEL = 3'd2,
		ST_IRQ_DEFERRED = 3'd3,
		ST_BUSY         = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] port;
		logic       hpd_level;
		logic       hpd_irq;
	} evt_t;

	typedef struct packed {
		logic [CFG_TICK_W-1:0]  spacing_ticks;
		logic [CFG_TICK_W-1:0]  pulse_ticks;
		logic [CFG_PORTS_W-1:0] ports_in_use;
	} cfg_t;

	typedef struct packed {
		logic       adv;
		logic       tick;
		logic       load;
		logic [1:0] port;
	} spc_ctl_t;

	typedef struct packed {
		status_t    status;
		logic       hpd_asserted;
		logic       owner_valid;
		logic [1:0] owner_port;
		logic [1:0] path_sel;
		logic       pulse_busy;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/core/dphpd_cfg_regs.sv
// Configuration registers: spacing width, pulse width, ports in use.
// Depends on dphpd_pkg.
`default_nettype none

module dphpd_cfg_regs
	import dphpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [1:0]            wr_index,
	input  wire logic [CFG_TICK_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spacing_ticks <= SPACING_RST;
			cfg_q.pulse_ticks   <= PULSE_RST;
			cfg_q.ports_in_use  <= PORTS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SPACING: cfg_q.spacing_ticks <= wr_data;
				CFG_PULSE:   cfg_q.pulse_ticks   <= wr_data;
				CFG_PORTS:   cfg_q.ports_in_use  <= wr_data[CFG_PORTS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/dphpd_spacing.sv
// Per-port spacing counters: tick down, reload on request.
// Depends on dphpd_pkg.
`default_nettype none

module dphpd_spacing
	import dphpd_pkg::*;
#(
	parameter int MAX_PORTS  = MAX_PORTS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire spc_ctl_t              ctl,
	input  wire logic [TIMER_BITS-1:0] reload,
	output logic [MAX_PORTS-1:0]       zero_now,
	output logic [MAX_PORTS-1:0]       zero_next
);

	logic [TIMER_BITS-1:0] cnt_q [MAX_PORTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PORTS; i++) cnt_q[i] <= '0;
		end else if (ctl.adv) begin
			for (int i = 0; i < MAX_PORTS; i++) begin
				if (ctl.load && 32'(ctl.port) == i)
					cnt_q[i] <= reload;
				else if (ctl.tick && cnt_q[i] != '0)
					cnt_q[i] <= cnt_q[i] - 1'b1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_PORTS; i++) begin
			zero_now[i]  = (cnt_q[i] == '0);
			zero_next[i] = (cnt_q[i] <= TIMER_BITS'(1));
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dphpd_event.sv
// Ownership, aux path, IRQ pulse state and per-event result.
// Depends on dphpd_pkg; drives the dphpd_spacing counters.
`default_nettype none

module dphpd_event
	import dphpd_pkg::*;
#(
	parameter int MAX_PORTS  = MAX_PORTS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire evt_t            item,
	input  wire cfg_t            cfg,
	input  wire logic [MAX_PORTS-1:0] zero_now,
	input  wire logic [MAX_PORTS-1:0] zero_next,
	output spc_ctl_t             spc,
	output res_t                 res
);

	logic                  owner_q, owner_n;
	logic [1:0]            owner_idx_q, owner_idx_n;
	logic [1:0]            path_q, path_n;
	logic [TIMER_BITS-1:0] pulse_left_q, pulse_left_n;
	logic                  pend_q, pend_n;
	logic [1:0]            pulse_port_q, pulse_port_n;

	logic                  busy, port_ok, is_owner;
	logic                  p_zero, pp_zero_next;
	logic [TIMER_BITS-1:0] pulse_w;
	status_t               status;

	assign pulse_w = TIMER_BITS'(cfg.pulse_ticks);
	assign busy    = pend_q || (pulse_left_q != '0);
	assign port_ok = ({1'b0, item.port} < cfg.ports_in_use) && (32'(item.port) < MAX_PORTS);
	assign is_owner = owner_q && (owner_idx_q == item.port);

	always_comb begin
		p_zero       = 1'b0;
		pp_zero_next = 1'b0;
		for (int i = 0; i < MAX_PORTS; i++) begin
			if (32'(item.port) == i) p_zero = zero_now[i];
			if (32'(pulse_port_q) == i) pp_zero_next = zero_next[i];
		end
	end

	always_comb begin
		owner_n      = owner_q;
		owner_idx_n  = owner_idx_q;
		path_n       = path_q;
		pulse_left_n = pulse_left_q;
		pend_n       = pend_q;
		pulse_port_n = pulse_port_q;
		status       = ST_APPLIED;
		spc.adv      = adv;
		spc.tick     = 1'b0;
		spc.load     = 1'b0;
		spc.port     = item.port;

		case (item.action) inside
			ACT_TICK: begin
				spc.tick = 1'b1;
				spc.port = pulse_port_q;
				if (pulse_left_q != '0) begin
					pulse_left_n = pulse_left_q - 1'b1;
					if (pulse_left_q == TIMER_BITS'(1)) spc.load = 1'b1;
				end else if (pend_q && pp_zero_next) begin
					pend_n = 1'b0;
					if (pulse_w == '0) spc.load = 1'b1;
					else pulse_left_n = pulse_w;
				end
			end
			ACT_ATTENTION, ACT_UNATTACH: begin
				if (busy) begin
					status = ST_BUSY;
				end else if (port_ok) begin
					if (item.action == ACT_UNATTACH) begin
						if (is_owner) owner_n = 1'b0;
					end else if (owner_q && !is_owner) begin
						status = ST_OTHER_OWNS;
					end else begin
						if (item.hpd_level) path_n = item.port;
						if (item.hpd_irq && !item.hpd_level) begin
							status = ST_IRQ_NO_LEVEL;
						end else if (item.hpd_irq && is_owner) begin
							pulse_port_n = item.port;
							if (p_zero) begin
								if (pulse_w == '0) spc.load = 1'b1;
								else pulse_left_n = pulse_w;
							end else begin
								pend_n = 1'b1;
								status = ST_IRQ_DEFERRED;
							end
						end else begin
							if (item.hpd_level && !owner_q) begin
								owner_n     = 1'b1;
								owner_idx_n = item.port;
							end else if (!item.hpd_level && is_owner) begin
								owner_n = 1'b0;
							end
							spc.load = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q      <= 1'b0;
			owner_idx_q  <= '0;
			path_q       <= '0;
			pulse_left_q <= '0;
			pend_q       <= 1'b0;
			pulse_port_q <= '0;
		end else if (adv) begin
			owner_q      <= owner_n;
			owner_idx_q  <= owner_idx_n;
			path_q       <= path_n;
			pulse_left_q <= pulse_left_n;
			pend_q       <= pend_n;
			pulse_port_q <= pulse_port_n;
		end
	end

	always_comb begin
		res.status       = status;
		res.hpd_asserted = owner_n && (pulse_left_n == '0);
		res.owner_valid  = owner_n;
		res.owner_port   = owner_idx_n;
		res.path_sel     = path_n;
		res.pulse_busy   = pend_n || (pulse_left_n != '0);
	end

endmodule

`default_nettype wire

// File: rtl/core/dp_hpd_port_arbiter.sv
// Top level of the DP hot-plug port arbiter: input stage, result stage.
// Depends on dphpd_pkg, dphpd_cfg_regs, dphpd_spacing, dphpd_event.
//
// Usage:
//   Event channel (in_valid/in_ready): one beat per event (attention,
//   unattach or tick) with port, hpd_level and hpd_irq. Result channel
//   (out_valid/out_ready): one beat per event, carrying status and the
//   line state after that event. Config channel (cfg_valid/cfg_ready):
//   cfg_index 0 spacing, 1 pulse width, 2 ports in use; always ready.
//   Throughput: one event per clock unless out_ready stalls, set by the
//   single input register feeding the event logic and the result
//   register; an accepted beat passes through both to out_valid.
//   Reset: owner, aux path, pulse and spacing counters clear at once and
//   the config takes its defaults (2000, 500, 2); no clearing pass.
//   Receiver stall: the result register holds, the input register fills,
//   then in_ready drops until out_ready returns.
`default_nettype none

module dp_hpd_port_arbiter
	import dphpd_pkg::*;
#(
	parameter int MAX_PORTS  = MAX_PORTS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            action,
	input  wire logic [1:0]            port,
	input  wire logic                  hpd_level,
	input  wire logic                  hpd_irq,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [2:0]                 status,
	output logic                       hpd_asserted,
	output logic                       owner_valid,
	output logic [1:0]                 owner_port,
	output logic [1:0]                 path_sel,
	output logic                       pulse_busy,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_TICK_W-1:0] cfg_data
);

	evt_t     item_s1;
	logic     v_s1;
	res_t     res_s2;
	logic     v_s2;
	logic     adv;
	cfg_t     cfg;
	spc_ctl_t spc;
	res_t     res;
	logic [MAX_PORTS-1:0] zero_now, zero_next;

	assign cfg_ready = 1'b1;
	assign adv       = v_s1 && (!v_s2 || out_ready);
	assign in_ready  = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv) v_s2 <= 1'b1;
			else if (out_ready) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action    <= action;
			item_s1.port      <= port;
			item_s1.hpd_level <= hpd_level;
			item_s1.hpd_irq   <= hpd_irq;
		end
		if (adv) res_s2 <= res;
	end

	dphpd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dphpd_spacing #(
		.MAX_PORTS  (MAX_PORTS),
		.TIMER_BITS (TIMER_BITS)
	) u_spacing (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (spc),
		.reload    (TIMER_BITS'(cfg.spacing_ticks)),
		.zero_now  (zero_now),
		.zero_next (zero_next)
	);

	dphpd_event #(
		.MAX_PORTS  (MAX_PORTS),
		.TIMER_BITS (TIMER_BITS)
	) u_event (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item      (item_s1),
		.cfg       (cfg),
		.zero_now  (zero_now),
		.zero_next (zero_next),
		.spc       (spc),
		.res       (res)
	);

	assign out_valid    = v_s2;
	assign status       = res_s2.status;
	assign hpd_asserted = res_s2.hpd_asserted;
	assign owner_valid  = res_s2.owner_valid;
	assign owner_port   = res_s2.owner_port;
	assign path_sel     = res_s2.path_sel;
	assign pulse_busy   = res_s2.pulse_busy;

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a held result");

	a_hpd_owner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hpd_asserted |-> owner_valid)
		else $error("hpd driven high with no owner");

	a_defer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_IRQ_DEFERRED |-> pulse_busy)
		else $error("deferred irq without a pending pulse");

endmodule

`default_nettype wire

// File: verif/tb_dp_hpd_port_arbiter.sv
`timescale 1ns / 100ps
// Testbench for dp_hpd_port_arbiter: directed and random event streams under random
// handshake gaps, each result beat checked against a line-ownership predictor.
// Depends on dphpd_pkg and the arbiter RTL; needs no files or arguments.

module tb_dp_hpd_port_arbiter
	import dphpd_pkg::*;
();

	localparam logic [1:0] ACT_UNKNOWN = 2'd3;
	localparam int LIMIT_CYCLES = 500000;
	localparam int RANDOM_PHASES = 10;

	class hpd_line_board;
		logic [CFG_TICK_W-1:0]  spacing_cfg;
		logic [CFG_TICK_W-1:0]  pulse_cfg;
		logic [CFG_PORTS_W-1:0] ports_cfg;
		logic                   owner_flag;
		logic [1:0]             owner_idx;
		logic [1:0]             path;
		logic [CFG_TICK_W-1:0]  spacing_left [MAX_PORTS_DEF];
		logic [CFG_TICK_W-1:0]  pulse_left;
		logic                   pulse_pending;
		logic [1:0]             pulse_port;
		res_t                   lines_due [$];
		int                     mismatches;
		int                     lines_checked;
		int                     status_seen [5];

		function new();
			spacing_cfg = SPACING_RST;
			pulse_cfg = PULSE_RST;
			ports_cfg = PORTS_RST;
			owner_flag = 1'b0;
			owner_idx = '0;
			path = '0;
			foreach (spacing_left[i]) spacing_left[i] = '0;
			pulse_left = '0;
			pulse_pending = 1'b0;
			pulse_port = '0;
			mismatches = 0;
			lines_checked = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [CFG_TICK_W-1:0] data);
			case (idx)
				CFG_SPACING: spacing_cfg = data;
				CFG_PULSE:   pulse_cfg = data;
				CFG_PORTS:   ports_cfg = data[CFG_PORTS_W-1:0];
				default: ;
			endcase
		endfunction

		function void finish_pulse();
			pulse_left = '0;
			spacing_left[pulse_port] = spacing_cfg;
		endfunction

		function void start_pulse();
			pulse_pending = 1'b0;
			if (pulse_cfg == '0) finish_pulse();
			else pulse_left = pulse_cfg;
		endfunction

		function void predict_line(evt_t e);
			res_t    line;
			status_t st;
			logic    holds;
			int      i;
			st = ST_APPLIED;
			case (e.action) inside
				ACT_TICK: begin
					for (i = 0; i < MAX_PORTS_DEF; i++)
						if (spacing_left[i] != '0) spacing_left[i] = spacing_left[i] - 1'b1;
					if (pulse_left != '0) begin
						pulse_left = pulse_left - 1'b1;
						if (pulse_left == '0) finish_pulse();
					end else if (pulse_pending && spacing_left[pulse_port] == '0) begin
						start_pulse();
					end
				end
				ACT_ATTENTION, ACT_UNATTACH: begin
					if (pulse_pending || pulse_left != '0) begin
						st = ST_BUSY;
					end else if (e.port < ports_cfg) begin
						if (e.action == ACT_UNATTACH) begin
							if (owner_flag && owner_idx == e.port) owner_flag = 1'b0;
						end else if (owner_flag && owner_idx != e.port) begin
							st = ST_OTHER_OWNS;
						end else begin
							holds = owner_flag && owner_idx == e.port;
							if (e.hpd_level) path = e.port;
							if (e.hpd_irq && !e.hpd_level) begin
								st = ST_IRQ_NO_LEVEL;
							end else if (e.hpd_irq && holds) begin
								pulse_port = e.port;
								if (spacing_left[e.port] == '0) begin
									start_pulse();
								end else begin
									pulse_pending = 1'b1;
									st = ST_IRQ_DEFERRED;
								end
							end else begin
								if (e.hpd_level && !owner_flag) begin
									owner_flag = 1'b1;
									owner_idx = e.port;
								end else if (!e.hpd_level && holds) begin
									owner_flag = 1'b0;
								end
								spacing_left[e.port] = spacing_cfg;
							end
						end
					end
				end
				default: ;
			endcase
			line.status = st;
			line.hpd_asserted = owner_flag && pulse_left == '0;
			line.owner_valid = owner_flag;
			line.owner_port = owner_idx;
			line.path_sel = path;
			line.pulse_busy = pulse_pending || pulse_left != '0;
			lines_due.push_back(line);
		endfunction

		task report(string msg);
			mismatches++;
			$display("mismatch: %s", msg);
		endtask

		task compare_field(string name, logic [2:0] got, logic [2:0] want);
			if (got !== want)
				report($sformatf("beat %0d %s got %0d want %0d", lines_checked, name,
					got, want));
		endtask

		task check_line(res_t got);
			res_t want;
			if (lines_due.size() == 0) begin
				report($sformatf("result beat with nothing pending, status %0d", got.status));
			end else begin
				want = lines_due.pop_front();
				lines_checked++;
				status_seen[int'(want.status)]++;
				compare_field("status", got.status, want.status);
				compare_field("hpd_asserted", 3'(got.hpd_asserted), 3'(want.hpd_asserted));
				compare_field("owner_valid", 3'(got.owner_valid), 3'(want.owner_valid));
				compare_field("owner_port", 3'(got.owner_port), 3'(want.owner_port));
				compare_field("path_sel", 3'(got.path_sel), 3'(want.path_sel));
				compare_field("pulse_busy", 3'(got.pulse_busy), 3'(want.pulse_busy));
			end
		endtask

		task close_out();
			if (lines_due.size() != 0)
				report($sformatf("%0d result beats never arrived", lines_due.size()));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            action;
	logic [1:0]            port;
	logic                  hpd_level;
	logic                  hpd_irq;
	logic                  out_valid;
	logic                  out_ready;
	logic [2:0]            status;
	logic                  hpd_asserted;
	logic                  owner_valid;
	logic [1:0]            owner_port;
	logic [1:0]            path_sel;
	logic                  pulse_busy;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [1:0]            cfg_index;
	logic [CFG_TICK_W-1:0] cfg_data;

	hpd_line_board sb = new();
	int  cycles;
	int  events_sent;
	int  ticks_sent;
	int  cfg_writes;
	int  settings_used;
	bit  no_gaps;
	bit  hold_off;
	int  hold_cycles;

	dp_hpd_port_arbiter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.port        (port),
		.hpd_level   (hpd_level),
		.hpd_irq     (hpd_irq),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.hpd_asserted(hpd_asserted),
		.owner_valid (owner_valid),
		.owner_port  (owner_port),
		.path_sel    (path_sel),
		.pulse_busy  (pulse_busy),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		else if (r < 88) return $urandom_range(1, 3);
		else if (r < 97) return $urandom_range(4, 12);
		else return $urandom_range(20, 60);
	endfunction

	task automatic send_event(input logic [1:0] act, input logic [1:0] p, input logic lvl,
			input logic irq);
		evt_t e;
		int   gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		e.action = act;
		e.port = p;
		e.hpd_level = lvl;
		e.hpd_irq = irq;
		in_valid <= 1'b1;
		action <= act;
		port <= p;
		hpd_level <= lvl;
		hpd_irq <= irq;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.predict_line(e);
		events_sent++;
		if (act == ACT_TICK) ticks_sent++;
		@(negedge clk);
	endtask

	task automatic wait_results();
		while (sb.lines_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_TICK_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_reg(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic [CFG_TICK_W-1:0] sp,
			input logic [CFG_TICK_W-1:0] pu, input logic [CFG_TICK_W-1:0] pt);
		in_valid <= 1'b0;
		wait_results();
		write_reg(CFG_SPACING, sp);
		write_reg(CFG_PULSE, pu);
		write_reg(CFG_PORTS, pt);
		settings_used++;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int held;
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				for (held = 0; held < hold_cycles; held++) @(negedge clk);
				hold_off = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			got.status = status_t'(status);
			got.hpd_asserted = hpd_asserted;
			got.owner_valid = owner_valid;
			got.owner_port = owner_port;
			got.path_sel = path_sel;
			got.pulse_busy = pulse_busy;
			sb.check_line(got);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int         ph;
		int         k;
		int         n_items;
		int         r;
		int         tick_pct;
		logic [1:0] a;
		logic [1:0] p;
		logic       lvl;
		logic       irq;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_TICK;
		port = '0;
		hpd_level = 1'b0;
		hpd_irq = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SPACING;
		cfg_data = '0;
		no_gaps = 1'b0;
		hold_off = 1'b0;
		hold_cycles = 0;
		events_sent = 0;
		ticks_sent = 0;
		cfg_writes = 0;
		settings_used = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		apply_setting(16'd2, 16'd2, 16'd3);
		send_event(ACT_TICK, 2'd0, 1'b0, 1'b0);
		send_event(ACT_ATTENTION, 2'd3, 1'b1, 1'b0);
		send_event(ACT_UNKNOWN, 2'd1, 1'b1, 1'b1);
		send_event(ACT_ATTENTION, 2'd0, 1'b0, 1'b1);
		send_event(ACT_ATTENTION, 2'd1, 1'b1, 1'b0);
		send_event(ACT_ATTENTION, 2'd0, 1'b1, 1'b0);
		send_event(ACT_ATTENTION, 2'd1, 1'b1, 1'b1);
		send_event(ACT_ATTENTION, 2'd1, 1'b1, 1'b0);
		send_event(ACT_UNATTACH, 2'd1, 1'b0, 1'b0);
		repeat (6) send_event(ACT_TICK, 2'd2, 1'b1, 1'b0);
		send_event(ACT_ATTENTION, 2'd1, 1'b1, 1'b1);
		repeat (2) send_event(ACT_TICK, 2'd1, 1'b0, 1'b1);
		send_event(ACT_ATTENTION, 2'd2, 1'b1, 1'b1);
		send_event(ACT_UNATTACH, 2'd0, 1'b0, 1'b0);
		send_event(ACT_ATTENTION, 2'd1, 1'b0, 1'b0);
		send_event(ACT_ATTENTION, 2'd2, 1'b1, 1'b1);
		send_event(ACT_UNATTACH, 2'd2, 1'b1, 1'b1);
		send_event(ACT_TICK, 2'd3, 1'b1, 1'b1);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: apply_setting(16'd1, 16'd1, 16'd4);
				1: apply_setting(16'd0, 16'd0, 16'd4);
				2: apply_setting(16'd5, 16'd3, 16'd1);
				3: begin
					apply_setting(16'd3, 16'd2, 16'd4);
					hold_cycles = 150;
					hold_off = 1'b1;
				end
				8: apply_setting(SPACING_RST, PULSE_RST, PORTS_RST);
				9: apply_setting(16'hFFFF, 16'hFFFF, 16'd4);
				default: apply_setting(16'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
						16'($urandom_range(1, 4)));
			endcase
			no_gaps = (ph == 3 || ph == 6);
			n_items = (ph >= 8) ? 40 : 90;
			for (k = 0; k < n_items; k++) begin
				r = $urandom_range(0, 99);
				tick_pct = (sb.pulse_pending || sb.pulse_left != '0) ? 70 : 30;
				if (r < tick_pct) a = ACT_TICK;
				else if (r < 88) a = ACT_ATTENTION;
				else if (r < 97) a = ACT_UNATTACH;
				else a = ACT_UNKNOWN;
				if ($urandom_range(0, 9) == 0) p = 2'($urandom_range(0, 3));
				else if (sb.owner_flag && $urandom_range(0, 1)) p = sb.owner_idx;
				else p = 2'($urandom_range(0, sb.ports_cfg - 1));
				lvl = ($urandom_range(0, 4) != 0);
				irq = ($urandom_range(0, 9) < 4);
				send_event(a, p, lvl, irq);
			end
		end

		in_valid <= 1'b0;
		wait_results();
		repeat (8) @(negedge clk);
		sb.close_out();
		$display("run: %0d events (%0d ticks), %0d result beats checked,",
			events_sent, ticks_sent, sb.lines_checked);
		$display("     %0d register writes over %0d settings; status mix: applied %0d,",
			cfg_writes, settings_used, sb.status_seen[0]);
		$display("     other owner %0d, irq without level %0d, deferred %0d, busy %0d",
			sb.status_seen[1], sb.status_seen[2], sb.status_seen[3], sb.status_seen[4]);
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
